// File: rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, held off during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// File: rtl/lzwc_pkg.sv
// ----------------------------------------------------------------------------
// lzwc_pkg
// Shared types and constants for the 12-bit LZW compressor.
// ----------------------------------------------------------------------------
package lzwc_pkg;

    localparam int CODE_W           = 12;
    localparam int BYTE_W           = 8;
    localparam int NIB_W            = 4;
    localparam int NF_W             = 13;
    localparam int DICT_ENTRIES_DEF = 4096;
    localparam int MAX_CODES        = 5;
    localparam int CNT_W            = 3;
    localparam int CFG_IDX_W        = 2;

    localparam logic [CODE_W-1:0] START_RST   = 12'd256;
    localparam logic [CODE_W-1:0] END_RST     = 12'd257;
    localparam logic [CODE_W-1:0] RESTART_RST = 12'd258;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START   = 2'd0,
        REG_END     = 2'd1,
        REG_RESTART = 2'd2
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SEARCH = 3'b010,
        ST_EMIT   = 3'b100
    } ctrl_state_t;

    typedef struct packed {
        logic load;     // take the accepted beat
        logic search;   // step the dictionary scan
        logic resolve;  // act on the search outcome
        logic emit;     // drain the code list into bytes
    } dp_cmd_t;

    typedef struct packed {
        logic in_message;
        logic search_done;
        logic emit_done;
    } dp_status_t;

endpackage

// File: rtl/lzwc_ctrl.sv
// ----------------------------------------------------------------------------
// lzwc_ctrl
// Sequencer: idle, dictionary search, byte emission.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lzwc_ctrl
    import lzwc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        in_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = status.in_message ? ST_SEARCH : ST_EMIT;
                end
            end
            ST_SEARCH:
            begin
                cmd.search = 1'b1;
                if (status.search_done)
                begin
                    cmd.resolve = 1'b1;
                    state_next  = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                cmd.emit = 1'b1;
                if (status.emit_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `ASSERT_NEXT(a_search_to_emit, clk, rst_n,
        (state_reg == ST_SEARCH) && status.search_done, state_reg == ST_EMIT)
    `ASSERT_NEXT(a_emit_to_idle, clk, rst_n,
        (state_reg == ST_EMIT) && status.emit_done, state_reg == ST_IDLE)

endmodule

// File: rtl/lzwc_dp.sv
// ----------------------------------------------------------------------------
// lzwc_dp
// Datapath: markers, dictionary RAM and scan, code list, 12-bit packer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lzwc_dp
    import lzwc_pkg::*;
#(
    parameter int DICT_ENTRIES = DICT_ENTRIES_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CODE_W-1:0]    cfg_data,
    input  logic [BYTE_W-1:0]    in_byte,
    input  logic                 in_final,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [BYTE_W-1:0]    out_byte,
    output logic                 run_end,
    output logic                 message_end,
    input  dp_cmd_t              cmd,
    output dp_status_t           status
);

    localparam int AW = $clog2(DICT_ENTRIES);
    localparam int ENT_W = CODE_W + BYTE_W;
    localparam logic [NF_W-1:0] TOP  = NF_W'(DICT_ENTRIES);
    localparam logic [NF_W-1:0] LAST = NF_W'(DICT_ENTRIES - 1);

    logic [CODE_W-1:0] start_reg, end_reg, restart_reg;
    logic [NF_W-1:0]   next_free_reg, next_free_next;
    logic [CODE_W-1:0] prefix_reg, prefix_next;
    logic [NIB_W-1:0]  nib_reg, nib_next;
    logic              pend_reg, pend_next;
    logic              in_msg_reg, in_msg_next;
    logic [BYTE_W-1:0] byte_reg;
    logic              fin_reg;

    logic [NF_W-1:0]   scan_reg;
    logic              cmp_valid_reg;
    logic [AW-1:0]     cmp_addr_reg;
    logic [ENT_W-1:0]  mem [DICT_ENTRIES];
    logic [ENT_W-1:0]  mem_q;

    logic [CODE_W-1:0] code_reg [MAX_CODES];
    logic [CODE_W-1:0] code_next [MAX_CODES];
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic              half_reg, half_next;

    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic              run_end_reg, msg_end_reg;

    logic [NF_W-1:0]   clear_val;
    logic              exhausted, rd_en, match, hit;
    logic              build, wr_en;
    logic [CODE_W-1:0] b0, b1, new_prefix;
    logic [1:0]        nb;
    logic              p_after;
    logic              out_free, emit_fire, finish;
    logic [CODE_W-1:0] cur;
    logic [BYTE_W-1:0] emit_byte;

    assign clear_val = NF_W'({1'b0, end_reg} + 13'd1);
    assign exhausted = (scan_reg >= next_free_reg) || (scan_reg >= TOP);
    assign rd_en     = cmd.search && !exhausted;
    assign match     = (mem_q[ENT_W-1:BYTE_W] == prefix_reg) && (mem_q[BYTE_W-1:0] == byte_reg);
    assign hit       = cmp_valid_reg && match;

    assign status.in_message  = in_msg_reg;
    assign status.search_done = hit || (!cmp_valid_reg && exhausted);
    assign status.emit_done   = (idx_reg == cnt_reg);

    // dictionary RAM: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[next_free_reg[AW-1:0]] <= {prefix_reg, byte_reg};
        end
        if (rd_en)
        begin
            mem_q <= mem[scan_reg[AW-1:0]];
        end
    end

    // outcome of a beat: base codes, new prefix, dictionary write and next free entry
    always_comb
    begin
        build          = 1'b0;
        wr_en          = 1'b0;
        b0             = prefix_reg;
        b1             = restart_reg;
        nb             = 2'd0;
        new_prefix     = prefix_reg;
        next_free_next = next_free_reg;
        in_msg_next    = in_msg_reg;
        if (cfg_write && (cfg_index == REG_END))
        begin
            next_free_next = NF_W'({1'b0, cfg_data} + 13'd1);
        end
        if (cmd.load && !in_msg_reg)
        begin
            build          = 1'b1;
            b0             = start_reg;
            nb             = 2'd1;
            new_prefix     = CODE_W'(in_byte);
            next_free_next = clear_val;
            in_msg_next    = !in_final;
        end
        else if (cmd.resolve)
        begin
            build       = 1'b1;
            in_msg_next = !fin_reg;
            if (hit)
            begin
                new_prefix = CODE_W'(cmp_addr_reg);
            end
            else
            begin
                new_prefix = CODE_W'(byte_reg);
                if (next_free_reg > LAST)
                begin
                    nb = 2'd1;
                end
                else if (next_free_reg == LAST)
                begin
                    nb             = 2'd2;
                    next_free_next = clear_val;
                end
                else
                begin
                    nb             = 2'd1;
                    wr_en          = 1'b1;
                    next_free_next = next_free_reg + 13'd1;
                end
            end
        end
    end

    // code list: base codes, then prefix and end markers on the last byte
    always_comb
    begin
        logic fin_now;
        fin_now = cmd.load ? in_final : fin_reg;
        p_after = pend_reg ^ !nb[0];
        for (int k = 0; k < MAX_CODES; k++)
        begin
            code_next[k] = code_reg[k];
        end
        cnt_next = cnt_reg;
        if (build)
        begin
            for (int k = 0; k < MAX_CODES; k++)
            begin
                if (k == 0 && nb != 2'd0)
                begin
                    code_next[k] = b0;
                end
                else if (k == 1 && nb == 2'd2)
                begin
                    code_next[k] = b1;
                end
                else if (k == int'(nb))
                begin
                    code_next[k] = new_prefix;
                end
                else
                begin
                    code_next[k] = end_reg;
                end
            end
            if (fin_now)
            begin
                cnt_next = CNT_W'(nb) + (p_after ? 3'd2 : 3'd3);
            end
            else
            begin
                cnt_next = CNT_W'(nb);
            end
        end
    end

    // packer: low byte first, high nibbles of a pair share the third byte
    assign out_free  = !out_valid_reg || out_ready;
    assign emit_fire = cmd.emit && (idx_reg != cnt_reg) && out_free;
    assign cur       = code_reg[idx_reg];

    always_comb
    begin
        emit_byte = cur[BYTE_W-1:0];
        finish    = 1'b1;
        nib_next  = nib_reg;
        pend_next = pend_reg;
        half_next = half_reg;
        if (!pend_reg)
        begin
            nib_next  = cur[CODE_W-1:BYTE_W];
            pend_next = 1'b1;
        end
        else if (!half_reg)
        begin
            finish    = 1'b0;
            half_next = 1'b1;
        end
        else
        begin
            emit_byte = {nib_reg, cur[CODE_W-1:BYTE_W]};
            nib_next  = '0;
            pend_next = 1'b0;
            half_next = 1'b0;
        end
        idx_next = idx_reg + (finish ? 3'd1 : 3'd0);
    end

    assign prefix_next = build ? new_prefix : prefix_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg     <= START_RST;
            end_reg       <= END_RST;
            restart_reg   <= RESTART_RST;
            next_free_reg <= NF_W'({1'b0, END_RST} + 13'd1);
            prefix_reg    <= '0;
            nib_reg       <= '0;
            pend_reg      <= 1'b0;
            in_msg_reg    <= 1'b0;
            scan_reg      <= '0;
            cmp_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            half_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < MAX_CODES; k++)
            begin
                code_reg[k] <= '0;
            end
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_START:   start_reg   <= cfg_data;
                    REG_END:     end_reg     <= cfg_data;
                    REG_RESTART: restart_reg <= cfg_data;
                    default:     ;
                endcase
            end
            next_free_reg <= next_free_next;
            prefix_reg    <= prefix_next;
            in_msg_reg    <= in_msg_next;
            cnt_reg       <= cnt_next;
            for (int k = 0; k < MAX_CODES; k++)
            begin
                code_reg[k] <= code_next[k];
            end
            if (cmd.load)
            begin
                scan_reg      <= clear_val;
                cmp_valid_reg <= 1'b0;
            end
            else if (cmd.search)
            begin
                cmp_valid_reg <= rd_en;
                if (rd_en)
                begin
                    scan_reg <= scan_reg + 13'd1;
                end
            end
            if (build)
            begin
                idx_reg  <= '0;
                half_reg <= 1'b0;
            end
            else if (emit_fire)
            begin
                idx_reg  <= idx_next;
                half_reg <= half_next;
                nib_reg  <= nib_next;
                pend_reg <= pend_next;
            end
            if (emit_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // input beat, scan address and the payload side of the output register
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            byte_reg <= in_byte;
            fin_reg  <= in_final;
        end
        if (rd_en)
        begin
            cmp_addr_reg <= scan_reg[AW-1:0];
        end
        if (emit_fire)
        begin
            out_byte_reg <= emit_byte;
            run_end_reg  <= finish && (idx_next == cnt_reg);
            msg_end_reg  <= finish && (idx_next == cnt_reg) && fin_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign run_end     = run_end_reg;
    assign message_end = msg_end_reg;

    `ASSERT_IMPL(a_idx_in_list, clk, rst_n, 1'b1, idx_reg <= cnt_reg)
    `ASSERT_IMPL(a_list_fits, clk, rst_n, 1'b1, cnt_reg <= 3'd5)
    `ASSERT_IMPL(a_half_needs_pend, clk, rst_n, half_reg, pend_reg)

endmodule

// File: rtl/lzw_compressor_12bit_packed.sv
// ----------------------------------------------------------------------------
// lzw_compressor_12bit_packed
// LZW compressor with 12-bit codes packed two codes to three bytes.
// ----------------------------------------------------------------------------
// One message byte is taken per input beat. The first byte of a message sends
// the start marker; each later byte is looked up as a (prefix, byte) pair by a
// linear scan of the dictionary RAM from end marker + 1 to the next free entry,
// one entry per cycle through the RAM's single read port. A beat gives up to
// 8 output bytes; a dictionary hit that is not the last byte of a message
// gives no byte at all. On a miss the pair is stored and the prefix code
// sent; once the dictionary reaches its last entry the prefix and the
// restart marker are sent and the dictionary starts afresh, keeping the byte
// packing position. The last byte of a message (in_final) flushes the prefix
// and one or two end markers so that the final three-byte group is complete;
// run_end flags the last output beat of each input beat and message_end the
// last beat of the message. The output register lets the next input beat be
// taken while the last output byte still waits. Marker registers are written
// through cfg_write/cfg_index/cfg_data; the user must write them only while
// idle, as the block itself does not enforce this. Writing the end marker
// empties the dictionary. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------

module lzw_compressor_12bit_packed
    import lzwc_pkg::*;
#(
    parameter int DICT_ENTRIES = DICT_ENTRIES_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CODE_W-1:0]    cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [BYTE_W-1:0]    in_byte,
    input  logic                 in_final,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [BYTE_W-1:0]    out_byte,
    output logic                 run_end,
    output logic                 message_end
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // sequencer
    lzwc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // dictionary, scan and byte packer
    lzwc_dp #(
        .DICT_ENTRIES (DICT_ENTRIES)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_byte     (in_byte),
        .in_final    (in_final),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .run_end     (run_end),
        .message_end (message_end),
        .cmd         (cmd),
        .status      (status)
    );

endmodule
